FILE: src/sme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// Opcodes, error codes and sequencer states shared by the execute block.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam logic [4:0] OP_PUSH    = 5'd0;
    localparam logic [4:0] OP_ADD     = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_MUL     = 5'd3;
    localparam logic [4:0] OP_DIV     = 5'd4;
    localparam logic [4:0] OP_SQRT    = 5'd5;
    localparam logic [4:0] OP_OUT     = 5'd6;
    localparam logic [4:0] OP_IN      = 5'd7;
    localparam logic [4:0] OP_PUSHREG = 5'd8;
    localparam logic [4:0] OP_POPREG  = 5'd9;
    localparam logic [4:0] OP_JMP     = 5'd10;
    localparam logic [4:0] OP_JB      = 5'd11;
    localparam logic [4:0] OP_JBE     = 5'd12;
    localparam logic [4:0] OP_JA      = 5'd13;
    localparam logic [4:0] OP_JAE     = 5'd14;
    localparam logic [4:0] OP_JE      = 5'd15;
    localparam logic [4:0] OP_JNE     = 5'd16;
    localparam logic [4:0] OP_CALL    = 5'd17;
    localparam logic [4:0] OP_RET     = 5'd18;
    localparam logic [4:0] OP_PUSHMEM = 5'd19;
    localparam logic [4:0] OP_POPMEM  = 5'd20;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EMPTY     = 4'd1;
    localparam logic [3:0] ERR_DIV_ZERO  = 4'd2;
    localparam logic [3:0] ERR_NEG_SQRT  = 4'd3;
    localparam logic [3:0] ERR_BAD_REG   = 4'd4;
    localparam logic [3:0] ERR_REG_UNSET = 4'd5;
    localparam logic [3:0] ERR_BAD_JUMP  = 4'd6;
    localparam logic [3:0] ERR_BAD_RET   = 4'd7;
    localparam logic [3:0] ERR_FULL      = 4'd8;
    localparam logic [3:0] ERR_BAD_ADDR  = 4'd9;
    localparam logic [3:0] ERR_CALL_FULL = 4'd10;

    localparam logic [1:0] ADDR_PROGRAM_LENGTH = 2'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MEM,
        ST_EXEC,
        ST_ITER,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Sequencer request toward the iterative unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iter_req_t;

endpackage
`default_nettype wire

FILE: src/sme_iter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sme_iter
// Iterative unit: truncating signed division (one quotient bit per cycle)
// and floor square root (one result bit per cycle).
// ----------------------------------------------------------------------------
module sme_iter
    import sme_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire iter_req_t   req,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      result
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        neg_reg, neg_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] bit_reg, bit_next;
    logic [31:0] rb;
    logic [31:0] ma, mb;

    assign ma = num[31] ? (32'd0 - num) : num;
    assign mb = den[31] ? (32'd0 - den) : den;
    assign rb = q_reg + bit_reg;

    // Start a request or advance one step of division or root
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        bit_next  = bit_reg;
        done      = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            sqrt_next = req.is_sqrt;
            neg_next  = num[31] ^ den[31];
            q_next    = 32'd0;
            if (req.is_sqrt)
            begin
                rem_next = num;
                bit_next = 32'h4000_0000;
            end
            else
            begin
                rem_next = 32'd0;
                d_next   = ma;
                bit_next = mb;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (sqrt_reg)
            begin
                if (cnt_reg < 6'd16)
                begin
                    if (rem_reg >= rb)
                    begin
                        rem_next = rem_reg - rb;
                        q_next   = (q_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        q_next = q_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            else if (cnt_reg < 6'd32)
            begin
                // restoring divide: bit_reg holds divisor
                if ({rem_reg, d_reg[31]} >= {1'b0, bit_reg})
                begin
                    rem_next = 32'({rem_reg, d_reg[31]} - {1'b0, bit_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], d_reg[31]};
                    q_next   = {q_reg[30:0], 1'b0};
                end
                d_next = {d_reg[30:0], 1'b0};
            end
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign result = (!sqrt_reg && neg_reg) ? (32'd0 - q_reg) : q_reg;

    // Hold iteration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        bit_reg  <= bit_next;
    end

endmodule
`default_nettype wire

FILE: src/stack_machine_execute_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one stack machine instruction per request.
// ----------------------------------------------------------------------------
// Sequence: a taken request passes ST_READ (read stack memory), ST_EXEC
//   (compute) and ST_WRITE (write back); pushmem adds ST_MEM, div/sqrt ST_ITER.
// Flow: one request at a time; a new one is taken only after ST_OUT ends,
//   which waits while res_stall stays high.
// Reset: after rst_n a clearing pass zeroes the data RAM, one word per cycle,
//   during which in_stall stays high.
module stack_machine_execute_top
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int CALL_DEPTH  = 32,
    parameter int NUM_REGS    = 8,
    parameter int RAM_WORDS   = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  opcode,
    input  wire logic [31:0] operand,
    input  wire logic [31:0] input_value,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [15:0]      next_pc,
    output logic             out_valid,
    output logic [31:0]      out_value,
    output logic [3:0]       error_code
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int AW = $clog2(RAM_WORDS);
    localparam int VC = $clog2(STACK_DEPTH + 1);
    localparam int RC = $clog2(CALL_DEPTH + 1);

    // Memories
    logic [31:0] vstack [STACK_DEPTH];
    logic [15:0] rstack [CALL_DEPTH];
    logic [31:0] dram   [RAM_WORDS];
    logic [31:0] rfile  [NUM_REGS];
    logic [NUM_REGS-1:0] rvalid_reg;

    logic [15:0] plen_reg;
    logic [15:0] pc_reg, pc_next;
    logic [VC-1:0] vcnt_reg, vcnt_next;
    logic [RC-1:0] rcnt_reg, rcnt_next;
    state_t state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;

    // latched request
    logic [4:0]  opc_reg;
    logic [31:0] opd_reg, iv_reg;
    logic [31:0] top_reg, sec_reg, ram_q;
    logic [15:0] ret_q;
    logic [31:0] res_reg, res_next;

    // result registers
    logic        rv_reg, rv_next;
    logic [15:0] npc_reg, npc_next;
    logic        ov_reg, ov_next;
    logic [31:0] oval_reg, oval_next;
    logic [3:0]  err_reg, err_next;

    logic [SW-1:0] top_idx, sec_idx;
    logic [CW-1:0] rtop_idx;

    // write controls
    logic          vs_we;
    logic [SW-1:0] vs_wa;
    logic [31:0]   vs_wd;
    logic          rs_we;
    logic          rf_we;
    logic          dr_we;
    logic [AW-1:0] dr_wa;
    logic [31:0]   dr_wd;

    iter_req_t   ireq;
    logic        idone;
    logic [31:0] ires;

    logic        reg_ok, target_ok, take;
    logic [RW-1:0] ridx;
    logic [31:0] rval;
    logic        accept;

    assign pready   = 1'b1;
    assign prdata   = {16'd0, plen_reg};
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign top_idx  = SW'(vcnt_reg - VC'(1));
    assign sec_idx  = SW'(vcnt_reg - VC'(2));
    assign rtop_idx = CW'(rcnt_reg - RC'(1));
    assign reg_ok   = opd_reg < 32'(NUM_REGS);
    assign ridx     = RW'(opd_reg);
    assign rval     = rfile[ridx];
    assign target_ok = (opd_reg >= 32'd1) && (opd_reg <= {16'd0, plen_reg});

    // Config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plen_reg <= 16'hFFFF;
        else if (psel && penable && pwrite && paddr == ADDR_PROGRAM_LENGTH)
            plen_reg <= pwdata[15:0];
    end

    // Memory ports: registered reads, one write each
    always_ff @(posedge clk)
    begin
        top_reg <= vstack[top_idx];
        sec_reg <= vstack[sec_idx];
        ret_q   <= rstack[rtop_idx];
        ram_q   <= dram[AW'(rval)];
        if (vs_we)
            vstack[vs_wa] <= vs_wd;
        if (rs_we)
            rstack[CW'(rcnt_reg)] <= pc_reg + 16'd1;
        if (dr_we)
            dram[dr_wa] <= dr_wd;
        if (rf_we)
            rfile[ridx] <= top_reg;
    end

    // Latch request and register results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opc_reg <= opcode;
            opd_reg <= operand;
            iv_reg  <= input_value;
        end
        res_reg  <= res_next;
        npc_reg  <= npc_next;
        ov_reg   <= ov_next;
        oval_reg <= oval_next;
        err_reg  <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= 16'd0;
            vcnt_reg   <= '0;
            rcnt_reg   <= '0;
            rvalid_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            vcnt_reg  <= vcnt_next;
            rcnt_reg  <= rcnt_next;
            rv_reg    <= rv_next;
            if (rf_we)
                rvalid_reg[ridx] <= 1'b1;
        end
    end

    sme_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ireq),
        .num    (opc_reg == OP_SQRT ? top_reg : sec_reg),
        .den    (top_reg),
        .done   (idone),
        .result (ires)
    );

    // Sequencer: clear the data RAM after reset, then check, compute and commit one instruction
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        vcnt_next  = vcnt_reg;
        rcnt_next  = rcnt_reg;
        rv_next    = rv_reg;
        npc_next   = npc_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        err_next   = err_reg;
        res_next   = res_reg;
        vs_we = 1'b0; vs_wa = top_idx; vs_wd = res_reg;
        rs_we = 1'b0; rf_we = 1'b0;
        dr_we = 1'b0; dr_wa = AW'(clr_reg); dr_wd = 32'd0;
        ireq  = '{start: 1'b0, is_sqrt: 1'b0};
        take  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                dr_we    = 1'b1;
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(RAM_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (accept)
                    state_next = ST_READ;
            ST_READ:
                state_next = (opc_reg == OP_PUSHMEM) ? ST_MEM : ST_EXEC;
            ST_MEM:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                err_next   = ERR_NONE;
                ov_next    = 1'b0;
                oval_next  = 32'd0;
                npc_next   = pc_reg + 16'd1;
                state_next = ST_WRITE;
                case (opc_reg)
                    OP_PUSH, OP_IN:
                        if (vcnt_reg >= VC'(STACK_DEPTH)) err_next = ERR_FULL;
                        else
                        begin
                            res_next = (opc_reg == OP_PUSH) ? opd_reg : iv_reg;
                            if (opc_reg == OP_PUSH) npc_next = pc_reg + 16'd2;
                        end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        if (vcnt_reg < VC'(2)) err_next = ERR_EMPTY;
                        else if (opc_reg == OP_DIV && top_reg == 32'd0)
                            err_next = ERR_DIV_ZERO;
                        else if (opc_reg == OP_DIV)
                        begin
                            ireq.start = 1'b1;
                            state_next = ST_ITER;
                        end
                        else if (opc_reg == OP_ADD) res_next = sec_reg + top_reg;
                        else if (opc_reg == OP_SUB) res_next = sec_reg - top_reg;
                        else res_next = sec_reg * top_reg;
                    OP_SQRT:
                        if (vcnt_reg < VC'(1)) err_next = ERR_EMPTY;
                        else if (top_reg[31]) err_next = ERR_NEG_SQRT;
                        else
                        begin
                            ireq = '{start: 1'b1, is_sqrt: 1'b1};
                            state_next = ST_ITER;
                        end
                    OP_OUT:
                        if (vcnt_reg < VC'(1)) err_next = ERR_EMPTY;
                        else
                        begin
                            ov_next   = 1'b1;
                            oval_next = top_reg;
                        end
                    OP_PUSHREG, OP_PUSHMEM:
                        if (!reg_ok) err_next = ERR_BAD_REG;
                        else if (!rvalid_reg[ridx]) err_next = ERR_REG_UNSET;
                        else if (opc_reg == OP_PUSHMEM && rval >= 32'(RAM_WORDS))
                            err_next = ERR_BAD_ADDR;
                        else if (vcnt_reg >= VC'(STACK_DEPTH)) err_next = ERR_FULL;
                        else
                        begin
                            res_next = (opc_reg == OP_PUSHREG) ? rval : ram_q;
                            npc_next = pc_reg + 16'd2;
                        end
                    OP_POPREG:
                        if (!reg_ok) err_next = ERR_BAD_REG;
                        else if (vcnt_reg < VC'(1)) err_next = ERR_EMPTY;
                        else npc_next = pc_reg + 16'd2;
                    OP_POPMEM:
                        if (!reg_ok) err_next = ERR_BAD_REG;
                        else if (!rvalid_reg[ridx]) err_next = ERR_REG_UNSET;
                        else if (rval >= 32'(RAM_WORDS)) err_next = ERR_BAD_ADDR;
                        else if (vcnt_reg < VC'(1)) err_next = ERR_EMPTY;
                        else npc_next = pc_reg + 16'd2;
                    OP_JMP:
                        if (!target_ok) err_next = ERR_BAD_JUMP;
                        else npc_next = opd_reg[15:0];
                    OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE:
                        if (!target_ok) err_next = ERR_BAD_JUMP;
                        else if (vcnt_reg < VC'(2)) err_next = ERR_EMPTY;
                        else
                        begin
                            case (opc_reg)
                                OP_JB:  take = $signed(sec_reg) <  $signed(top_reg);
                                OP_JBE: take = $signed(sec_reg) <= $signed(top_reg);
                                OP_JA:  take = $signed(sec_reg) >  $signed(top_reg);
                                OP_JAE: take = $signed(sec_reg) >= $signed(top_reg);
                                OP_JE:  take = sec_reg == top_reg;
                                default: take = sec_reg != top_reg;
                            endcase
                            npc_next = take ? opd_reg[15:0] : pc_reg + 16'd2;
                        end
                    OP_CALL:
                        if (!target_ok) err_next = ERR_BAD_JUMP;
                        else if (rcnt_reg >= RC'(CALL_DEPTH)) err_next = ERR_CALL_FULL;
                        else npc_next = opd_reg[15:0];
                    OP_RET:
                        if (rcnt_reg == '0 || ret_q >= plen_reg) err_next = ERR_BAD_RET;
                        else npc_next = ret_q + 16'd1;
                    default: ;
                endcase
            end
            ST_ITER:
                if (idone)
                begin
                    res_next   = ires;
                    state_next = ST_WRITE;
                end
            ST_WRITE:
            begin
                // commit state unless the instruction erred
                if (err_reg == ERR_NONE)
                begin
                    pc_next = npc_reg;
                    case (opc_reg)
                        OP_PUSH, OP_IN, OP_PUSHREG, OP_PUSHMEM:
                        begin
                            vs_we = 1'b1; vs_wa = SW'(vcnt_reg);
                            vcnt_next = vcnt_reg + VC'(1);
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            vs_we = 1'b1; vs_wa = sec_idx;
                            vcnt_next = vcnt_reg - VC'(1);
                        end
                        OP_SQRT:
                            vs_we = 1'b1;
                        OP_OUT:
                            vcnt_next = vcnt_reg - VC'(1);
                        OP_POPREG:
                        begin
                            rf_we = 1'b1;
                            vcnt_next = vcnt_reg - VC'(1);
                        end
                        OP_POPMEM:
                        begin
                            dr_we = 1'b1; dr_wa = AW'(rval); dr_wd = top_reg;
                            vcnt_next = vcnt_reg - VC'(1);
                        end
                        OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE:
                            vcnt_next = vcnt_reg - VC'(2);
                        OP_CALL:
                        begin
                            rs_we = 1'b1;
                            rcnt_next = rcnt_reg + RC'(1);
                        end
                        OP_RET:
                            rcnt_next = rcnt_reg - RC'(1);
                        default: ;
                    endcase
                end
                else
                    npc_next = pc_reg;
                rv_next    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (!res_stall)
                begin
                    rv_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign res_valid  = rv_reg;
    assign next_pc    = npc_reg;
    assign out_valid  = ov_reg;
    assign out_value  = oval_reg;
    assign error_code = err_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept) else $error("accept while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= VC'(STACK_DEPTH)) else $error("value count overflow");
    a_err_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && err_reg != ERR_NONE) |=> $stable(pc_reg))
        else $error("pc changed on error");
    a_result_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> $past(state_reg) == ST_WRITE)
        else $error("result without commit");

endmodule
`default_nettype wire
